### src/trst_pkg.sv
// Shared constants, event codes and controller/datapath handshake types.
package trst_pkg;

  localparam int MAX_SLOTS      = 10;
  localparam int SLOT_COUNT_DEF = 10;
  localparam int BYTE_W         = 8;
  localparam int COORD_W        = 12;
  localparam int SLOT_W         = 4;
  localparam int KIND_W         = 2;
  localparam int M_DATA_W       = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_CONTACT = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_SYNC    = 2'd2
  } kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_byte;
    logic flush_emit;
    logic flush_adv;
    logic sync_emit;
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic slot_event;
    logic idx_last;
    logic out_free;
  } status_t;

endpackage

### src/trst_ctrl.sv
// Controller state machine: byte intake, slot flush walk and frame sync.
module trst_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  input  trst_pkg::status_t status,
  output trst_pkg::cmd_t    cmd
);
  import trst_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FLUSH = 3'b010,
    ST_SYNC  = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.take_byte = in_valid;
        if (in_valid && in_last) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // A slot with nothing to report is skipped without waiting on the output.
        if (!status.slot_event || status.out_free) begin
          cmd.flush_emit = status.slot_event;
          cmd.flush_adv  = 1'b1;
          if (status.idx_last) begin
            state_next = ST_SYNC;
          end
        end
      end
      ST_SYNC: begin
        if (status.out_free) begin
          cmd.sync_emit = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### src/trst_datapath.sv
// Datapath: frame parsing, slot position store, active flags and output register.
module trst_datapath #(
  parameter int SLOT_COUNT = trst_pkg::SLOT_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [trst_pkg::BYTE_W-1:0]     in_byte,
  input  trst_pkg::cmd_t                  cmd,
  output trst_pkg::status_t               status,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [trst_pkg::M_DATA_W-1:0]   out_data,
  output logic [trst_pkg::KIND_W-1:0]     out_user,
  output logic                            out_last
);
  import trst_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CUR_W = $clog2(SLOT_COUNT + 1);
  localparam int PAD_W = M_DATA_W - SLOT_W - 2 * COORD_W;

  logic [1:0]             hdr;
  logic [1:0]             pos;
  logic [CUR_W-1:0]       grp;
  logic [CUR_W-1:0]       cursor;
  logic [MAX_SLOTS-1:0]   bitmap;
  logic [2*BYTE_W-1:0]    group_bytes;
  logic [SLOT_COUNT-1:0]  active;
  logic [COORD_W-1:0]     slot_x [SLOT_COUNT];
  logic [COORD_W-1:0]     slot_y [SLOT_COUNT];
  logic [IDX_W-1:0]       idx;

  logic [SLOT_COUNT-1:0]  cand;
  logic                   found;
  logic [IDX_W-1:0]       hit;
  logic                   assign_now;

  kind_t                  o_kind;
  logic [SLOT_W-1:0]      o_slot;
  logic [COORD_W-1:0]     o_x;
  logic [COORD_W-1:0]     o_y;
  logic                   o_last;

  // Lowest set slot at or above the cursor receives the finished group.
  always_comb begin
    found = 1'b0;
    hit   = '0;
    for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
      cand[s] = bitmap[s] && (CUR_W'(s) >= cursor);
      if (cand[s]) begin
        found = 1'b1;
        hit   = IDX_W'(s);
      end
    end
  end

  assign assign_now = cmd.take_byte && (hdr == 2'd2) && (grp < CUR_W'(SLOT_COUNT))
                      && (pos == 2'd2);

  assign status.slot_event = bitmap[idx] || active[idx];
  assign status.idx_last   = (idx == IDX_W'(SLOT_COUNT - 1));
  assign status.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr         <= '0;
      pos         <= '0;
      grp         <= '0;
      cursor      <= '0;
      bitmap      <= '0;
      group_bytes <= '0;
      active      <= '0;
      idx         <= '0;
      out_valid   <= 1'b0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
        slot_x[s] <= '0;
        slot_y[s] <= '0;
      end
    end else begin
      if (cmd.take_byte) begin
        if (hdr == 2'd0) begin
          bitmap[BYTE_W-1:0] <= in_byte;
          hdr                <= 2'd1;
        end else if (hdr == 2'd1) begin
          bitmap[MAX_SLOTS-1:BYTE_W] <= in_byte[5:4];
          hdr                        <= 2'd2;
        end else if (grp < CUR_W'(SLOT_COUNT)) begin
          unique case (pos)
            2'd0: begin
              group_bytes[2*BYTE_W-1:BYTE_W] <= in_byte;
              pos                            <= 2'd1;
            end
            2'd1: begin
              group_bytes[BYTE_W-1:0] <= in_byte;
              pos                     <= 2'd2;
            end
            default: begin
              pos <= 2'd0;
              grp <= grp + CUR_W'(1);
            end
          endcase
        end
      end

      if (assign_now) begin
        if (found) begin
          slot_x[hit] <= {group_bytes[15:12], group_bytes[7:0]};
          slot_y[hit] <= {group_bytes[11:8], in_byte};
          cursor      <= CUR_W'(hit) + CUR_W'(1);
        end else begin
          cursor <= CUR_W'(SLOT_COUNT);
        end
      end

      if (cmd.flush_emit) begin
        active[idx] <= bitmap[idx];
      end
      if (cmd.flush_adv && !status.idx_last) begin
        idx <= idx + IDX_W'(1);
      end

      if (cmd.sync_emit) begin
        hdr         <= '0;
        pos         <= '0;
        grp         <= '0;
        cursor      <= '0;
        bitmap      <= '0;
        group_bytes <= '0;
        idx         <= '0;
      end

      if (cmd.flush_emit || cmd.sync_emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.flush_emit) begin
      o_slot <= SLOT_W'(idx);
      o_last <= 1'b0;
      if (bitmap[idx]) begin
        o_kind <= KIND_CONTACT;
        o_x    <= slot_x[idx];
        o_y    <= slot_y[idx];
      end else begin
        o_kind <= KIND_RELEASE;
        o_x    <= '0;
        o_y    <= '0;
      end
    end else if (cmd.sync_emit) begin
      o_kind <= KIND_SYNC;
      o_slot <= '0;
      o_x    <= '0;
      o_y    <= '0;
      o_last <= 1'b1;
    end
  end

  assign out_data = {{PAD_W{1'b0}}, o_y, o_x, o_slot};
  assign out_user = o_kind;
  assign out_last = o_last;

endmodule

### src/touch_report_slot_tracker_core.sv
// Top level of the touch report slot tracker: controller plus datapath.
//
//  channel   dir  tdata                      tuser            tlast
//  s_axis    in   [7:0] frame_byte           -                frame_end
//  m_axis    out  [3:0] slot_number,         [1:0] event_kind run_last
//                 [15:4] pos_x, [27:16] pos_y, [31:28] zero
//
// A byte without tlast is accepted whenever the controller is idle, so header
// and group bytes can stream at one beat per cycle. The beat with tlast starts
// the flush walk, one slot per cycle while the output can take each event, then
// the sync beat, so a frame end holds s_axis_tready low until the sync beat is sent.
// A stalled output beat holds the walk on a slot that has an event to report.
// Synchronous reset clears all slot positions and marks every slot inactive.
module touch_report_slot_tracker_core #(
  parameter int SLOT_COUNT = trst_pkg::SLOT_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [trst_pkg::BYTE_W-1:0]     s_axis_tdata,  // [7:0] frame_byte
  input  logic                            s_axis_tlast,  // frame_end
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [trst_pkg::M_DATA_W-1:0]   m_axis_tdata,  // slot_number, pos_x, pos_y
  output logic [trst_pkg::KIND_W-1:0]     m_axis_tuser,  // [1:0] event_kind
  output logic                            m_axis_tlast   // run_last
);
  import trst_pkg::*;

  cmd_t    cmd;
  status_t status;

  trst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  trst_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (s_axis_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

endmodule

### src/trst_checker.sv
// Port-level checks for the slot tracker, bound to the top level.
module trst_checker #(
  parameter int SLOT_COUNT = trst_pkg::SLOT_COUNT_DEF
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            s_axis_tlast,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [trst_pkg::M_DATA_W-1:0]   m_axis_tdata,
  input logic [trst_pkg::KIND_W-1:0]     m_axis_tuser,
  input logic                            m_axis_tlast
);
  import trst_pkg::*;

  // The sync beat, and only it, closes the run.
  a_last_is_sync: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == KIND_SYNC)))
    else $error("tlast does not match a sync beat");

  // After a frame end beat the input stays closed while the slots are walked.
  a_flush_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input accepted during flush");

  // Release beats name a slot that exists and carry no position.
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == KIND_RELEASE)) |->
      ((m_axis_tdata[3:0] < SLOT_W'(SLOT_COUNT)) && (m_axis_tdata[27:4] == '0)))
    else $error("bad release beat");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled output beat changed");

endmodule

bind touch_report_slot_tracker_core trst_checker #(.SLOT_COUNT(SLOT_COUNT)) u_trst_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
